>>> sv/qae_pkg.sv
// shared widths, register codes, side-band structs and arctangent table
`timescale 1ns / 1ps
`default_nettype none
package qae_pkg;
    localparam int DATA_W           = 16;
    localparam int ROWS_W           = 5;
    localparam int PROD_W           = 32;
    localparam int SUM_W            = 34;
    localparam int MAG_W            = 25;
    localparam int SQR_W            = 50;
    localparam int SQ_W             = 52;
    localparam int ROOT_W           = 26;
    localparam int SREM_W           = 29;
    localparam int XY_W             = 28;
    localparam int Z_W              = 32;
    localparam int ANG_W            = 33;
    localparam int PRD_W            = 58;
    localparam int NUM_W            = 59;
    localparam int Q_W              = 34;
    localparam int DREM_W           = 26;
    localparam int SCL_W            = 50;
    localparam int RSH              = 26;
    localparam int OUT_W            = 23;
    localparam int OUT_SAT          = 4194303;
    localparam int TDATA_W          = 88;
    localparam int CFG_AW           = 3;
    localparam int ATAN_ENTRIES     = 24;
    localparam int MAX_ROWS_DEF     = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    typedef enum logic [CFG_AW-1:0] {
        REG_TARGET_X  = 3'd0,
        REG_TARGET_Y  = 3'd1,
        REG_TARGET_Z  = 3'd2,
        REG_TARGET_W  = 3'd3,
        REG_STRENGTH  = 3'd4,
        REG_BOUND     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                  ok;
        logic [MAG_W-1:0]      ew;
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
    } sq_side_t;

    typedef struct packed {
        logic                  ok;
        logic                  tiny;
        logic [ROOT_W-1:0]     s;
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
    } cd_side_t;

    typedef struct packed {
        logic       ok;
        logic       tiny;
        logic [2:0] neg;
    } dv_side_t;

    // atan(2^-i) in q.30
    function automatic logic [Z_W-1:0] atan_q30(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:  v = 32'd843314857;
            1:  v = 32'd497837829;
            2:  v = 32'd263043837;
            3:  v = 32'd133525159;
            4:  v = 32'd67021687;
            5:  v = 32'd33543516;
            6:  v = 32'd16775851;
            7:  v = 32'd8388437;
            8:  v = 32'd4194283;
            9:  v = 32'd2097149;
            10: v = 32'd1048576;
            11: v = 32'd524288;
            12: v = 32'd262144;
            13: v = 32'd131072;
            14: v = 32'd65536;
            15: v = 32'd32768;
            16: v = 32'd16384;
            17: v = 32'd8192;
            18: v = 32'd4096;
            19: v = 32'd2048;
            20: v = 32'd1024;
            21: v = 32'd512;
            22: v = 32'd256;
            23: v = 32'd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // magnitude rounded half away from zero to q.20
    function automatic logic [MAG_W-1:0] rnd_mag(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] m;
        logic [SUM_W-1:0] r;
        m = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
        r = (m + SUM_W'(128)) >> 8;
        return r[MAG_W-1:0];
    endfunction
endpackage
`default_nettype wire

>>> sv/qae_sqrt_cell.sv
// one digit cell of the pipelined integer square root
`timescale 1ns / 1ps
`default_nettype none
module qae_sqrt_cell
    import qae_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              valid_i,
    input  wire logic [SQ_W-1:0]   rad_i,
    input  wire logic [SREM_W-1:0] rem_i,
    input  wire logic [ROOT_W-1:0] root_i,
    input  wire logic [SIDE_W-1:0] side_i,
    output logic                   valid_o,
    output logic [SQ_W-1:0]        rad_o,
    output logic [SREM_W-1:0]      rem_o,
    output logic [ROOT_W-1:0]      root_o,
    output logic [SIDE_W-1:0]      side_o
);
    logic              valid_reg;
    logic [SQ_W-1:0]   rad_reg;
    logic [SREM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [SREM_W-1:0] t;
    logic [SREM_W-1:0] trial;
    logic              ge;

    always_comb begin
        t     = {rem_i[SREM_W-3:0], rad_i[SQ_W-1 -: 2]};
        trial = SREM_W'({root_i, 2'b01});
        ge    = (t >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= {rad_i[SQ_W-3:0], 2'b00};
            rem_reg  <= ge ? (t - trial) : t;
            root_reg <= {root_i[ROOT_W-2:0], ge};
            side_reg <= side_i;
        end
    end

    assign valid_o = valid_reg;
    assign rad_o   = rad_reg;
    assign rem_o   = rem_reg;
    assign root_o  = root_reg;
    assign side_o  = side_reg;
endmodule
`default_nettype wire

>>> sv/qae_cordic_cell.sv
// one vectoring step of the pipelined arctangent
`timescale 1ns / 1ps
`default_nettype none
module qae_cordic_cell
    import qae_pkg::*;
#(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   valid_i,
    input  wire logic signed [XY_W-1:0] x_i,
    input  wire logic signed [XY_W-1:0] y_i,
    input  wire logic signed [Z_W-1:0]  z_i,
    input  wire logic [SIDE_W-1:0]      side_i,
    output logic                        valid_o,
    output logic signed [XY_W-1:0]      x_o,
    output logic signed [XY_W-1:0]      y_o,
    output logic signed [Z_W-1:0]       z_o,
    output logic [SIDE_W-1:0]           side_o
);
    localparam logic [Z_W-1:0] ANGLE = atan_q30(STEP);

    logic                   valid_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [SIDE_W-1:0]      side_reg;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    assign dx = y_i >>> STEP;
    assign dy = x_i >>> STEP;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (y_i > 0) begin
                x_reg <= x_i + dx;
                y_reg <= y_i - dy;
                z_reg <= z_i + signed'(ANGLE);
            end else begin
                x_reg <= x_i - dx;
                y_reg <= y_i + dy;
                z_reg <= z_i - signed'(ANGLE);
            end
            side_reg <= side_i;
        end
    end

    assign valid_o = valid_reg;
    assign x_o     = x_reg;
    assign y_o     = y_reg;
    assign z_o     = z_reg;
    assign side_o  = side_reg;
endmodule
`default_nettype wire

>>> sv/qae_div_cell.sv
// one quotient bit of the three-lane pipelined divider
`timescale 1ns / 1ps
`default_nettype none
module qae_div_cell
    import qae_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   valid_i,
    input  wire logic [2:0][DREM_W-1:0] rem_i,
    input  wire logic [2:0][Q_W-1:0]    sh_i,
    input  wire logic [ROOT_W-1:0]      d_i,
    input  wire logic [SIDE_W-1:0]      side_i,
    output logic                        valid_o,
    output logic [2:0][DREM_W-1:0]      rem_o,
    output logic [2:0][Q_W-1:0]         sh_o,
    output logic [ROOT_W-1:0]           d_o,
    output logic [SIDE_W-1:0]           side_o
);
    logic                   valid_reg;
    logic [2:0][DREM_W-1:0] rem_reg;
    logic [2:0][Q_W-1:0]    sh_reg;
    logic [ROOT_W-1:0]      d_reg;
    logic [SIDE_W-1:0]      side_reg;
    logic [2:0][DREM_W:0]   t;
    logic [2:0][DREM_W:0]   diff;
    logic [2:0]             ge;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t[i]    = {rem_i[i], sh_i[i][Q_W-1]};
            ge[i]   = (t[i] >= (DREM_W+1)'(d_i));
            diff[i] = t[i] - (DREM_W+1)'(d_i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rem_reg[i] <= ge[i] ? diff[i][DREM_W-1:0] : t[i][DREM_W-1:0];
                sh_reg[i]  <= {sh_i[i][Q_W-2:0], ge[i]};
            end
            d_reg    <= d_i;
            side_reg <= side_i;
        end
    end

    assign valid_o = valid_reg;
    assign rem_o   = rem_reg;
    assign sh_o    = sh_reg;
    assign d_o     = d_reg;
    assign side_o  = side_reg;
endmodule
`default_nettype wire

>>> sv/quaternion_attitude_error.sv
// top level: quaternion error to scaled rotation vector pipeline
// pipeline: five front stages, 26 square root cells, the arctangent cells, two numerator
//   stages, 34 divider cells, one scaling stage and the output register
// throughput: one item per cycle; the whole pipeline holds while a result is not taken
// reset: synchronous active-low aresetn clears every stage valid and sets the config registers (w to 16384)
`timescale 1ns / 1ps
`default_nettype none
module quaternion_attitude_error
    import qae_pkg::*;
#(
    parameter int MAX_ROWS     = MAX_ROWS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // current_x, current_y, current_z, current_w, rows_used, time_step, zero fill
    input  wire logic [TDATA_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // error_x, error_y, error_z, impulse_limit, limit_off, rows_added
    output logic [TDATA_W-1:0]      m_tdata,
    input  wire logic               cfg_we,
    input  wire logic [CFG_AW-1:0]  cfg_addr,
    input  wire logic [DATA_W-1:0]  cfg_wdata
);
    localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int SQS_W = $bits(sq_side_t);
    localparam int CDS_W = $bits(cd_side_t);
    localparam int DVS_W = $bits(dv_side_t);

    logic signed [DATA_W-1:0] tgt_x_reg, tgt_y_reg, tgt_z_reg, tgt_w_reg;
    logic [DATA_W-1:0]        strength_reg, bound_reg;
    logic                     en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_x_reg    <= '0;
            tgt_y_reg    <= '0;
            tgt_z_reg    <= '0;
            tgt_w_reg    <= 16'sd16384;
            strength_reg <= '0;
            bound_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_TARGET_X: tgt_x_reg    <= cfg_wdata;
                REG_TARGET_Y: tgt_y_reg    <= cfg_wdata;
                REG_TARGET_Z: tgt_z_reg    <= cfg_wdata;
                REG_TARGET_W: tgt_w_reg    <= cfg_wdata;
                REG_STRENGTH: strength_reg <= cfg_wdata;
                REG_BOUND:    bound_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // front end: products
    logic signed [DATA_W-1:0] cx, cy, cz, cw;
    logic [ROWS_W-1:0]        rows;
    logic [DATA_W-1:0]        dt;
    logic                     in_ok;
    assign cx   = s_tdata[15:0];
    assign cy   = s_tdata[31:16];
    assign cz   = s_tdata[47:32];
    assign cw   = s_tdata[63:48];
    assign rows = s_tdata[68:64];
    assign dt   = s_tdata[84:69];
    assign in_ok = (dt != '0) && (strength_reg != '0)
                   && !(({3'b000, rows} + 8'd3) > 8'(MAX_ROWS));

    logic                     a_valid_reg, a_ok_reg;
    logic signed [PROD_W-1:0] p_reg [16];

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ok_reg <= in_ok;
            p_reg[0]  <= tgt_w_reg * cw;
            p_reg[1]  <= tgt_x_reg * cx;
            p_reg[2]  <= tgt_y_reg * cy;
            p_reg[3]  <= tgt_z_reg * cz;
            p_reg[4]  <= tgt_w_reg * cx;
            p_reg[5]  <= tgt_x_reg * cw;
            p_reg[6]  <= tgt_y_reg * cz;
            p_reg[7]  <= tgt_z_reg * cy;
            p_reg[8]  <= tgt_w_reg * cy;
            p_reg[9]  <= tgt_x_reg * cz;
            p_reg[10] <= tgt_y_reg * cw;
            p_reg[11] <= tgt_z_reg * cx;
            p_reg[12] <= tgt_w_reg * cz;
            p_reg[13] <= tgt_x_reg * cy;
            p_reg[14] <= tgt_y_reg * cx;
            p_reg[15] <= tgt_z_reg * cw;
        end
    end

    // sums of the error quaternion, q.28
    logic                    b_valid_reg, b_ok_reg;
    logic signed [SUM_W-1:0] ew_reg, ex_reg, ey_reg, ez_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_ok_reg <= a_ok_reg;
            ew_reg <= SUM_W'(p_reg[0]) + SUM_W'(p_reg[1]) + SUM_W'(p_reg[2])
                      + SUM_W'(p_reg[3]);
            ex_reg <= SUM_W'(p_reg[5]) + SUM_W'(p_reg[7]) - SUM_W'(p_reg[4])
                      - SUM_W'(p_reg[6]);
            ey_reg <= SUM_W'(p_reg[9]) + SUM_W'(p_reg[10]) - SUM_W'(p_reg[8])
                      - SUM_W'(p_reg[11]);
            ez_reg <= SUM_W'(p_reg[14]) + SUM_W'(p_reg[15]) - SUM_W'(p_reg[12])
                      - SUM_W'(p_reg[13]);
        end
    end

    // shortest path flip and rounding to q.20
    logic     c_valid_reg;
    sq_side_t c_side_reg;
    logic     flip;
    assign flip = ew_reg[SUM_W-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg.ok     <= b_ok_reg;
            c_side_reg.ew     <= rnd_mag(ew_reg);
            c_side_reg.mag[0] <= rnd_mag(ex_reg);
            c_side_reg.mag[1] <= rnd_mag(ey_reg);
            c_side_reg.mag[2] <= rnd_mag(ez_reg);
            c_side_reg.neg    <= {ez_reg[SUM_W-1] ^ flip, ey_reg[SUM_W-1] ^ flip,
                                  ex_reg[SUM_W-1] ^ flip};
        end
    end

    // squares and their sum
    logic              d_valid_reg, e_valid_reg;
    sq_side_t          d_side_reg, e_side_reg;
    logic [SQR_W-1:0]  sq_reg [3];
    logic [SQ_W-1:0]   e_rad_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_side_reg <= c_side_reg;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= c_side_reg.mag[i] * c_side_reg.mag[i];
            end
            e_side_reg <= d_side_reg;
            e_rad_reg  <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // square root chain
    logic              sq_valid [ROOT_W+1];
    logic [SQ_W-1:0]   sq_rad   [ROOT_W+1];
    logic [SREM_W-1:0] sq_rem   [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root  [ROOT_W+1];
    logic [SQS_W-1:0]  sq_side  [ROOT_W+1];

    assign sq_valid[0] = e_valid_reg;
    assign sq_rad[0]   = e_rad_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = e_side_reg;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        qae_sqrt_cell #(.SIDE_W(SQS_W)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .valid_i (sq_valid[k]),
            .rad_i   (sq_rad[k]),
            .rem_i   (sq_rem[k]),
            .root_i  (sq_root[k]),
            .side_i  (sq_side[k]),
            .valid_o (sq_valid[k+1]),
            .rad_o   (sq_rad[k+1]),
            .rem_o   (sq_rem[k+1]),
            .root_o  (sq_root[k+1]),
            .side_o  (sq_side[k+1])
        );
    end

    // arctangent chain
    sq_side_t sq_out;
    cd_side_t cd_in;
    assign sq_out = sq_side_t'(sq_side[ROOT_W]);
    always_comb begin
        cd_in.ok    = sq_out.ok;
        cd_in.tiny  = (sq_root[ROOT_W] < ROOT_W'(2));
        cd_in.s     = sq_root[ROOT_W];
        cd_in.mag   = sq_out.mag;
        cd_in.neg   = sq_out.neg;
    end

    logic                   cd_valid [STEPS+1];
    logic signed [XY_W-1:0] cd_x     [STEPS+1];
    logic signed [XY_W-1:0] cd_y     [STEPS+1];
    logic signed [Z_W-1:0]  cd_z     [STEPS+1];
    logic [CDS_W-1:0]       cd_side  [STEPS+1];

    assign cd_valid[0] = sq_valid[ROOT_W];
    assign cd_x[0]     = XY_W'({1'b0, sq_out.ew});
    assign cd_y[0]     = XY_W'({1'b0, sq_root[ROOT_W]});
    assign cd_z[0]     = '0;
    assign cd_side[0]  = cd_in;

    for (genvar k = 0; k < STEPS; k++) begin : g_cordic
        qae_cordic_cell #(.STEP(k), .SIDE_W(CDS_W)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .valid_i (cd_valid[k]),
            .x_i     (cd_x[k]),
            .y_i     (cd_y[k]),
            .z_i     (cd_z[k]),
            .side_i  (cd_side[k]),
            .valid_o (cd_valid[k+1]),
            .x_o     (cd_x[k+1]),
            .y_o     (cd_y[k+1]),
            .z_o     (cd_z[k+1]),
            .side_o  (cd_side[k+1])
        );
    end

    // numerators |e| * angle + s / 2
    cd_side_t          cd_out;
    logic [ANG_W-1:0]  angle;
    logic              f_valid_reg, g_valid_reg;
    cd_side_t          f_side_reg;
    logic [PRD_W-1:0]  f_prod_reg [3];
    dv_side_t          g_side_reg;
    logic [ROOT_W-1:0] g_d_reg;
    logic [2:0][DREM_W-1:0] g_rem_reg;
    logic [2:0][Q_W-1:0]    g_sh_reg;
    logic [2:0][NUM_W-1:0]  num;

    assign cd_out = cd_side_t'(cd_side[STEPS]);
    assign angle  = cd_z[STEPS][Z_W-1] ? '0 : ANG_W'({cd_z[STEPS][Z_W-2:0], 1'b0});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = NUM_W'(f_prod_reg[i]) + NUM_W'(f_side_reg.s >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_side_reg <= cd_out;
            for (int i = 0; i < 3; i++) begin
                f_prod_reg[i] <= cd_out.mag[i] * angle;
                g_rem_reg[i]  <= DREM_W'(num[i][NUM_W-1:Q_W]);
                g_sh_reg[i]   <= num[i][Q_W-1:0];
            end
            g_d_reg          <= f_side_reg.s;
            g_side_reg.ok    <= f_side_reg.ok;
            g_side_reg.tiny  <= f_side_reg.tiny;
            g_side_reg.neg   <= f_side_reg.neg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= cd_valid[STEPS];
            g_valid_reg <= f_valid_reg;
        end
    end

    // divider chain
    logic                   dv_valid [Q_W+1];
    logic [2:0][DREM_W-1:0] dv_rem   [Q_W+1];
    logic [2:0][Q_W-1:0]    dv_sh    [Q_W+1];
    logic [ROOT_W-1:0]      dv_d     [Q_W+1];
    logic [DVS_W-1:0]       dv_side  [Q_W+1];

    assign dv_valid[0] = g_valid_reg;
    assign dv_rem[0]   = g_rem_reg;
    assign dv_sh[0]    = g_sh_reg;
    assign dv_d[0]     = g_d_reg;
    assign dv_side[0]  = g_side_reg;

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        qae_div_cell #(.SIDE_W(DVS_W)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .valid_i (dv_valid[k]),
            .rem_i   (dv_rem[k]),
            .sh_i    (dv_sh[k]),
            .d_i     (dv_d[k]),
            .side_i  (dv_side[k]),
            .valid_o (dv_valid[k+1]),
            .rem_o   (dv_rem[k+1]),
            .sh_o    (dv_sh[k+1]),
            .d_o     (dv_d[k+1]),
            .side_o  (dv_side[k+1])
        );
    end

    // strength scaling, rounding and saturation
    logic             h_valid_reg;
    dv_side_t         h_side_reg;
    logic [SCL_W-1:0] h_scl_reg [3];
    logic [SCL_W-1:0] rnd [3];
    logic [OUT_W-1:0] err [3];
    logic [OUT_W-1:0] mag_sat;
    logic [TDATA_W-1:0] m_tdata_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = (h_scl_reg[i] + (SCL_W'(1) << (RSH - 1))) >> RSH;
            mag_sat = (rnd[i] > SCL_W'(OUT_SAT)) ? OUT_W'(OUT_SAT) : rnd[i][OUT_W-1:0];
            if (!h_side_reg.ok || h_side_reg.tiny) begin
                err[i] = '0;
            end else if (h_side_reg.neg[i]) begin
                err[i] = OUT_W'(-mag_sat);
            end else begin
                err[i] = mag_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_side_reg <= dv_side_t'(dv_side[Q_W]);
            for (int i = 0; i < 3; i++) begin
                h_scl_reg[i] <= dv_sh[Q_W][i] * strength_reg;
            end
            m_tdata_reg[22:0]  <= err[0];
            m_tdata_reg[45:23] <= err[1];
            m_tdata_reg[68:46] <= err[2];
            if (!h_side_reg.ok) begin
                m_tdata_reg[84:69] <= '0;
                m_tdata_reg[85]    <= 1'b0;
                m_tdata_reg[87:86] <= 2'd0;
            end else begin
                m_tdata_reg[84:69] <= (bound_reg == '0) ? '1 : bound_reg;
                m_tdata_reg[85]    <= (bound_reg == '0);
                m_tdata_reg[87:86] <= 2'd3;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            h_valid_reg  <= dv_valid[Q_W];
            m_tvalid_reg <= h_valid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule
`default_nettype wire

>>> verif/qae_checker.sv
// checker: predicts each attitude error result and compares it with the block output
`timescale 1ns / 1ps
`default_nettype none
module qae_checker
    import qae_pkg::*;
#(
    parameter int MAX_ROWS     = MAX_ROWS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,
    input  wire logic               cfg_we,
    input  wire logic [CFG_AW-1:0]  cfg_addr,
    input  wire logic [DATA_W-1:0]  cfg_wdata,
    output int                      fail_count,
    output int                      pending
);
    typedef struct packed {
        logic [1:0]       rows_added;
        logic             limit_off;
        logic [15:0]      impulse_limit;
        logic [OUT_W-1:0] error_z;
        logic [OUT_W-1:0] error_y;
        logic [OUT_W-1:0] error_x;
    } att_result_t;

    logic signed [15:0] tgt_x, tgt_y, tgt_z, tgt_w;
    logic [15:0] strength, bound;
    att_result_t expected_q[$];

    function automatic longint rnd_shift(longint v, int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (v >= 0) return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic longint vector_atan(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + longint'(atan_q30(i));
            end else begin
                x = x - dx; y = y + dy; z = z - longint'(atan_q30(i));
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    function automatic logic [OUT_W-1:0] scaled_axis(longint e, longint unsigned s,
                                                     longint angle);
        longint unsigned mag, r;
        longint v;
        mag = (e < 0) ? longint'(-e) : longint'(e);
        r = (mag * longint'(angle) + s / 2) / s;
        v = longint'(r * longint'(strength));
        if (e < 0) v = -v;
        v = rnd_shift(v, RSH);
        if (v > OUT_SAT) v = OUT_SAT;
        if (v < -OUT_SAT) v = -OUT_SAT;
        return v[OUT_W-1:0];
    endfunction

    function automatic att_result_t predict_attitude_error(logic [TDATA_W-1:0] d);
        att_result_t res;
        longint cx, cy, cz, cw, tx, ty, tz, tw, ew, ex, ey, ez, angle;
        longint unsigned s;
        logic [4:0] rows;
        logic [15:0] dt;
        res = '0;
        cx = -longint'($signed(d[15:0]));
        cy = -longint'($signed(d[31:16]));
        cz = -longint'($signed(d[47:32]));
        cw = longint'($signed(d[63:48]));
        rows = d[68:64];
        dt = d[84:69];
        tx = tgt_x; ty = tgt_y; tz = tgt_z; tw = tgt_w;
        if (dt == 0 || strength == 0 || int'(rows) + 3 > MAX_ROWS) return res;
        ew = tw * cw - tx * cx - ty * cy - tz * cz;
        ex = tw * cx + tx * cw + ty * cz - tz * cy;
        ey = tw * cy - tx * cz + ty * cw + tz * cx;
        ez = tw * cz + tx * cy - ty * cx + tz * cw;
        if (ew < 0) begin
            ew = -ew; ex = -ex; ey = -ey; ez = -ez;
        end
        ew = rnd_shift(ew, 8);
        ex = rnd_shift(ex, 8);
        ey = rnd_shift(ey, 8);
        ez = rnd_shift(ez, 8);
        s = int_sqrt(longint'(ex * ex + ey * ey + ez * ez));
        if (s >= 2) begin
            angle = 2 * vector_atan(longint'(s), ew);
            res.error_x = scaled_axis(ex, s, angle);
            res.error_y = scaled_axis(ey, s, angle);
            res.error_z = scaled_axis(ez, s, angle);
        end
        if (bound == 0) begin
            res.impulse_limit = 16'hFFFF;
            res.limit_off = 1'b1;
        end else begin
            res.impulse_limit = bound;
        end
        res.rows_added = 2'd3;
        return res;
    endfunction

    always @(posedge aclk) begin
        att_result_t got, exp_r;
        if (!aresetn) begin
            tgt_x <= '0; tgt_y <= '0; tgt_z <= '0; tgt_w <= 16'sd16384;
            strength <= '0; bound <= '0;
            expected_q = {};
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_TARGET_X: tgt_x <= cfg_wdata;
                    REG_TARGET_Y: tgt_y <= cfg_wdata;
                    REG_TARGET_Z: tgt_z <= cfg_wdata;
                    REG_TARGET_W: tgt_w <= cfg_wdata;
                    REG_STRENGTH: strength <= cfg_wdata;
                    REG_BOUND:    bound <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) expected_q.push_back(predict_attitude_error(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_q.size() == 0) begin
                    $error("unexpected item %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got != exp_r) fail_count <= fail_count + 1;
                    if (got.error_x != exp_r.error_x)
                        $error("error_x exp %h got %h", exp_r.error_x, got.error_x);
                    if (got.error_y != exp_r.error_y)
                        $error("error_y exp %h got %h", exp_r.error_y, got.error_y);
                    if (got.error_z != exp_r.error_z)
                        $error("error_z exp %h got %h", exp_r.error_z, got.error_z);
                    if (got.impulse_limit != exp_r.impulse_limit)
                        $error("impulse_limit exp %h got %h", exp_r.impulse_limit,
                               got.impulse_limit);
                    if (got.limit_off != exp_r.limit_off)
                        $error("limit_off exp %b got %b", exp_r.limit_off, got.limit_off);
                    if (got.rows_added != exp_r.rows_added)
                        $error("rows_added exp %d got %d", exp_r.rows_added, got.rows_added);
                end
            end
        end
        pending <= expected_q.size();
    end
endmodule
`default_nettype wire

>>> verif/tb_quaternion_attitude_error.sv
// testbench top: stimulus, stalls, configuration phases and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_quaternion_attitude_error;
    import qae_pkg::*;

    localparam logic [CFG_AW-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SPARE_B = 3'd7;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [DATA_W-1:0] cfg_wdata = '0;
    int fail_count, pending;
    int cycles = 0;
    int burst_left = 0;

    quaternion_attitude_error DUT (.*);
    qae_checker u_checker (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall pattern: a random mode is drawn and held for a random stretch
    int stall_mode = 0, stall_left = 0;
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 60);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_item(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                             logic [15:0] qw, logic [4:0] rows, logic [15:0] dt);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, dt, rows, qw, qz, qy, qx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [15:0] quat_part();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'sd16384;
            2: return -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [15:0] near_part(logic [15:0] v);
        return v + 16'($signed($urandom_range(0, 6)) - 3);
    endfunction

    task automatic random_item(logic [15:0] tx, logic [15:0] ty, logic [15:0] tz,
                               logic [15:0] tw);
        logic [4:0] rows;
        logic [15:0] dt;
        rows = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 13));
        dt = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 5) == 0)
            send_item(near_part(tx), near_part(ty), near_part(tz), near_part(tw), rows, dt);
        else
            send_item(quat_part(), quat_part(), quat_part(), quat_part(), rows, dt);
    endtask

    initial begin
        logic [15:0] tx, ty, tz, tw, gain, lim;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: strength zero rejects everything
        send_item(16'h0000, 16'h0000, 16'h0000, 16'sd16384, 5'd0, 16'd1);
        send_item(16'h1234, 16'hF000, 16'h0400, 16'h2000, 5'd3, 16'hFFFF);
        wait_drained();

        write_reg(REG_STRENGTH, 16'h0100);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h5555);
        send_item(16'h0000, 16'h0000, 16'h0000, 16'sd16384, 5'd0, 16'd1);
        send_item(16'h0000, 16'h0000, 16'h0000, -16'sd16384, 5'd0, 16'd1);
        send_item(16'sd16384, 16'h0000, 16'h0000, 16'h0000, 5'd13, 16'd1);
        send_item(16'h0000, -16'sd16384, 16'h0000, 16'h0000, 5'd14, 16'd1);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 5'd31, 16'hFFFF);
        send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 5'd0, 16'hFFFF);
        send_item(16'h8000, 16'h7FFF, 16'h0001, 16'h0000, 5'd2, 16'd0);
        send_item(16'h0001, 16'h0000, 16'h0000, 16'sd16384, 5'd5, 16'd7);
        send_item(16'h2D41, 16'h0000, 16'h0000, 16'h2D41, 5'd1, 16'h8000);
        send_item(16'hD2BF, 16'h2000, 16'hE000, 16'h2D41, 5'd12, 16'h0001);
        wait_drained();

        write_reg(REG_TARGET_X, 16'h8000);
        write_reg(REG_TARGET_Y, 16'h7FFF);
        write_reg(REG_TARGET_Z, 16'sd16384);
        write_reg(REG_TARGET_W, -16'sd16384);
        write_reg(REG_STRENGTH, 16'hFFFF);
        write_reg(REG_BOUND, 16'hFFFF);
        send_item(16'h0000, 16'h0000, 16'h0000, 16'sd16384, 5'd0, 16'd1);
        send_item(16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 5'd13, 16'hFFFF);
        send_item(16'sd16384, 16'h0000, -16'sd16384, 16'h0000, 5'd4, 16'd9);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            tx = quat_part(); ty = quat_part(); tz = quat_part(); tw = quat_part();
            case (phase % 4)
                0: gain = 16'd1;
                1: gain = 16'hFFFF;
                default: gain = 16'($urandom_range(1, 65535));
            endcase
            if (phase == 6) gain = 16'd0;
            lim = (phase % 3 == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            write_reg(REG_TARGET_X, tx);
            write_reg(REG_TARGET_Y, ty);
            write_reg(REG_TARGET_Z, tz);
            write_reg(REG_TARGET_W, tw);
            write_reg(REG_STRENGTH, gain);
            write_reg(REG_BOUND, lim);
            repeat ((phase == 6) ? 40 : 200) random_item(tx, ty, tz, tw);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
sv/qae_pkg.sv
sv/qae_sqrt_cell.sv
sv/qae_cordic_cell.sv
sv/qae_div_cell.sv
sv/quaternion_attitude_error.sv
verif/qae_checker.sv
verif/tb_quaternion_attitude_error.sv
